@@ hdl/lprd_pkg.sv @@
// ----------------------------------------------------------------------------
// lprd_pkg: shared types and constants for the request deframer
// Parse phases, byte roles, error codes and the per-byte result record.
// ----------------------------------------------------------------------------
package lprd_pkg;

  localparam int DEF_MAX_MSG = 4096;
  localparam int HDR_BYTES   = 4;
  localparam int ARG_IDX_W   = 10;

  typedef enum logic [2:0] {
    PH_LEN,
    PH_COUNT,
    PH_ARGLEN,
    PH_PAYLOAD,
    PH_ERR
  } lprd_phase_t;

  localparam logic [2:0] ROLE_LEN     = 3'd0;
  localparam logic [2:0] ROLE_COUNT   = 3'd1;
  localparam logic [2:0] ROLE_ARGLEN  = 3'd2;
  localparam logic [2:0] ROLE_PAYLOAD = 3'd3;
  localparam logic [2:0] ROLE_IGNORED = 3'd4;

  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_TOO_LONG  = 3'd1;
  localparam logic [2:0] ERR_UNDER_HDR = 3'd2;
  localparam logic [2:0] ERR_COUNT     = 3'd3;
  localparam logic [2:0] ERR_OVERRUN   = 3'd4;
  localparam logic [2:0] ERR_TRAILING  = 3'd5;

  typedef struct packed {
    logic [7:0]           data_byte;
    logic [2:0]           byte_role;
    logic [ARG_IDX_W-1:0] arg_index;
    logic                 arg_last;
    logic                 frame_last;
    logic [2:0]           error_code;
  } lprd_result_t;

endpackage

@@ hdl/lprd_parser.sv @@
// ----------------------------------------------------------------------------
// lprd_parser: framing state machine and per-byte tagging
// Holds the parse state; computes the tag of one byte and the next state.
// ----------------------------------------------------------------------------
module lprd_parser #(
  parameter int MAX_MSG = lprd_pkg::DEF_MAX_MSG
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic [7:0]           in_byte,
  output lprd_pkg::lprd_result_t result
);
  import lprd_pkg::*;

  localparam int CW = $clog2(MAX_MSG + 1);

  lprd_phase_t          phase, phase_next;
  logic [1:0]           hdr_cnt, hdr_cnt_next;
  logic [23:0]          hdr_word, hdr_word_next;
  logic [CW-1:0]        frame_left, frame_left_next;
  logic [CW-1:0]        args_left, args_left_next;
  logic [CW-1:0]        arg_left, arg_left_next;
  logic [ARG_IDX_W-1:0] arg_cnt, arg_cnt_next;

  logic [31:0]   w;
  logic          hdr_done;
  logic [CW-1:0] frame_dec, args_dec, arg_dec;
  logic          body_short;
  logic          arg_done;
  logic          done_frame_end;
  logic [2:0]    err;
  logic          flast;
  logic          alast;

  assign w         = {in_byte, hdr_word};
  assign hdr_done  = (hdr_cnt == 2'd3);
  assign frame_dec = (frame_left != '0) ? frame_left - CW'(1) : frame_left;
  assign args_dec  = (args_left  != '0) ? args_left  - CW'(1) : args_left;
  assign arg_dec   = (arg_left   != '0) ? arg_left   - CW'(1) : arg_left;
  assign body_short = (frame_dec < CW'(HDR_BYTES));

  // an argument completes: zero length header, or last payload byte
  assign arg_done = ((phase == PH_ARGLEN) && hdr_done && (w == 32'd0) &&
                     !(w > 32'(frame_dec))) ||
                    ((phase == PH_PAYLOAD) && (arg_dec == '0));
  assign done_frame_end = (args_dec == '0);

  // outputs of one byte
  always_comb begin
    err   = ERR_NONE;
    flast = 1'b0;
    alast = 1'b0;
    result.data_byte  = in_byte;
    result.byte_role  = ROLE_IGNORED;
    result.arg_index  = '0;
    unique case (phase)
      PH_LEN: begin
        result.byte_role = ROLE_LEN;
        if (hdr_done) begin
          if (w > 32'(MAX_MSG)) begin
            err = ERR_TOO_LONG;
          end else if (w < 32'(HDR_BYTES)) begin
            err = ERR_UNDER_HDR;
          end
        end
      end
      PH_COUNT: begin
        result.byte_role = ROLE_COUNT;
        if (hdr_done) begin
          if (w > 32'(MAX_MSG)) begin
            err = ERR_COUNT;
          end else if (w == 32'd0) begin
            if (frame_dec == '0) begin
              flast = 1'b1;
            end else begin
              err = ERR_TRAILING;
            end
          end else if (body_short) begin
            err = ERR_OVERRUN;
          end
        end
      end
      PH_ARGLEN, PH_PAYLOAD: begin
        result.byte_role = (phase == PH_ARGLEN) ? ROLE_ARGLEN : ROLE_PAYLOAD;
        result.arg_index = arg_cnt;
        if ((phase == PH_ARGLEN) && hdr_done && (w > 32'(frame_dec))) begin
          err = ERR_OVERRUN;
        end else if (arg_done) begin
          alast = 1'b1;
          if (done_frame_end) begin
            if (frame_dec == '0) begin
              flast = 1'b1;
            end else begin
              err = ERR_TRAILING;
            end
          end else if (body_short) begin
            err = ERR_OVERRUN;
          end
        end
      end
      default: begin
        result.byte_role = ROLE_IGNORED;
      end
    endcase
    result.arg_last   = alast;
    result.frame_last = flast;
    result.error_code = err;
  end

  // next state
  always_comb begin
    phase_next      = phase;
    hdr_cnt_next    = hdr_cnt;
    hdr_word_next   = hdr_word;
    frame_left_next = frame_left;
    args_left_next  = args_left;
    arg_left_next   = arg_left;
    arg_cnt_next    = arg_cnt;
    if (phase == PH_LEN || phase == PH_COUNT || phase == PH_ARGLEN) begin
      hdr_cnt_next = hdr_cnt + 2'd1;
      case (hdr_cnt)
        2'd0:    hdr_word_next[7:0]   = in_byte;
        2'd1:    hdr_word_next[15:8]  = in_byte;
        2'd2:    hdr_word_next[23:16] = in_byte;
        default: hdr_word_next        = '0;
      endcase
    end
    if (phase == PH_COUNT || phase == PH_ARGLEN || phase == PH_PAYLOAD) begin
      frame_left_next = frame_dec;
    end
    unique case (phase)
      PH_LEN: begin
        if (hdr_done) begin
          frame_left_next = w[CW-1:0];
          arg_cnt_next    = '0;
          phase_next      = PH_COUNT;
        end
      end
      PH_COUNT: begin
        if (hdr_done) begin
          if (w == 32'd0) begin
            phase_next = PH_LEN;
          end else begin
            args_left_next = w[CW-1:0];
            phase_next     = PH_ARGLEN;
          end
        end
      end
      PH_ARGLEN, PH_PAYLOAD: begin
        if (phase == PH_PAYLOAD) begin
          arg_left_next = arg_dec;
        end
        if (arg_done) begin
          arg_cnt_next   = arg_cnt + ARG_IDX_W'(1);
          args_left_next = args_dec;
          phase_next     = done_frame_end ? PH_LEN : PH_ARGLEN;
        end else if (phase == PH_ARGLEN && hdr_done) begin
          arg_left_next = w[CW-1:0];
          phase_next    = PH_PAYLOAD;
        end
      end
      default: begin
        phase_next = PH_ERR;
      end
    endcase
    if (err != ERR_NONE) begin
      phase_next = PH_ERR;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_LEN;
      hdr_cnt    <= '0;
      hdr_word   <= '0;
      frame_left <= '0;
      args_left  <= '0;
      arg_left   <= '0;
      arg_cnt    <= '0;
    end else if (en) begin
      phase      <= phase_next;
      hdr_cnt    <= hdr_cnt_next;
      hdr_word   <= hdr_word_next;
      frame_left <= frame_left_next;
      args_left  <= args_left_next;
      arg_left   <= arg_left_next;
      arg_cnt    <= arg_cnt_next;
    end
  end

`ifndef SYNTHESIS
  a_err_sticky: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_ERR) |=> (phase == PH_ERR))
    else $error("left error phase without reset");
  a_err_enters: assert property (@(posedge clk) disable iff (rst)
    (en && result.error_code != ERR_NONE) |=> (phase == PH_ERR))
    else $error("error reported but parser kept going");
  a_flast_clean: assert property (@(posedge clk) disable iff (rst)
    (en && result.frame_last) |-> (result.error_code == ERR_NONE && frame_dec == '0))
    else $error("frame end with error or body bytes left");
  a_flast_restart: assert property (@(posedge clk) disable iff (rst)
    (en && result.frame_last) |=> (phase == PH_LEN && hdr_cnt == 2'd0))
    else $error("frame end did not return to length header");
  a_payload_aligned: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_PAYLOAD) |-> (hdr_cnt == 2'd0 && arg_left != '0))
    else $error("payload phase with header bytes pending or empty argument");
`endif

endmodule

@@ hdl/length_prefixed_request_deframer.sv @@
// An accepted item is registered in the input register, then in the output register.
// 1 item per cycle unless out_stall holds the output; parse state updates once per byte.
// An empty input register accepts a new item while a finished result waits on the output.
// Reset (rst, synchronous): parser returns to expecting a frame length, all counters
// zero, both pipeline registers empty; an error latches until the next reset.
// ----------------------------------------------------------------------------
// length_prefixed_request_deframer: top level
// Input register, parser, output register; tags each request byte with role,
// argument index, argument/frame end marks and the first framing error.
// ----------------------------------------------------------------------------
module length_prefixed_request_deframer #(
  parameter int MAX_MSG = lprd_pkg::DEF_MAX_MSG
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [7:0]                     in_byte,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [7:0]                     data_byte,
  output logic [2:0]                     byte_role,
  output logic [lprd_pkg::ARG_IDX_W-1:0] arg_index,
  output logic                           arg_last,
  output logic                           frame_last,
  output logic [2:0]                     error_code
);
  import lprd_pkg::*;

  // input register stage
  logic       s1_valid;
  logic [7:0] s1_byte;

  // output register stage
  lprd_result_t res_comb;
  lprd_result_t res;

  logic out_open;   // output register can take an item this cycle
  logic adv;        // item moves from the input register through the parser
  logic in_take;

  assign out_open = !out_valid || !out_stall;
  assign adv      = s1_valid && out_open;
  assign in_stall = s1_valid && !out_open;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (adv) begin
      s1_valid <= 1'b0;
    end
  end

  // payload holds while stalled; no reset needed
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_byte <= in_byte;
    end
  end

  // the parser state commits only when its result is written out
  lprd_parser #(
    .MAX_MSG(MAX_MSG)
  ) u_parser (
    .clk     (clk),
    .rst     (rst),
    .en      (adv),
    .in_byte (s1_byte),
    .result  (res_comb)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_open) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res <= res_comb;
    end
  end

  assign data_byte  = res.data_byte;
  assign byte_role  = res.byte_role;
  assign arg_index  = res.arg_index;
  assign arg_last   = res.arg_last;
  assign frame_last = res.frame_last;
  assign error_code = res.error_code;

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for length_prefixed_request_deframer
// Feeds well-formed request frames with random content and random pacing,
// forces long output stalls and a full drain, sends one maximal frame, then
// ends the stream with one malformed frame and trailing noise. Every tagged
// byte is checked field by field against a cycle-free model of the parser.
// ----------------------------------------------------------------------------
module tb;
  import lprd_pkg::*;

  localparam int CLK_PERIOD     = 4;
  localparam int RESET_CYCLES   = 11;
  localparam int MAX_MSG        = 256;     // small limit so a full-size frame stays short
  localparam int SETTLE_CYCLES  = 8;       // margin after the last result for the pipeline to settle
  localparam int HOLD_CYCLES    = 400;     // long receiver hold-off
  localparam int TIMEOUT_CYCLES = 400_000;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_TOGGLE
  } stall_mode_t;

  // --------------------------------------------------------------------------
  // Clock, reset and DUT ports
  // --------------------------------------------------------------------------
  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 in_valid  = 1'b0;
  logic [7:0]           in_byte   = 8'h00;
  logic                 out_stall = 1'b0;
  logic                 in_stall;
  logic                 out_valid;
  logic [7:0]           data_byte;
  logic [2:0]           byte_role;
  logic [ARG_IDX_W-1:0] arg_index;
  logic                 arg_last;
  logic                 frame_last;
  logic [2:0]           error_code;

  always #(CLK_PERIOD / 2) clk = ~clk;

  length_prefixed_request_deframer #(
    .MAX_MSG(MAX_MSG)
  ) i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_byte    (in_byte),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .data_byte  (data_byte),
    .byte_role  (byte_role),
    .arg_index  (arg_index),
    .arg_last   (arg_last),
    .frame_last (frame_last),
    .error_code (error_code)
  );

  // --------------------------------------------------------------------------
  // Parser model: one call per accepted byte, returns the tag it must get
  // --------------------------------------------------------------------------
  lprd_phase_t          parse_ph;
  logic [1:0]           hdr_cnt;
  logic [31:0]          hdr_word;
  logic [12:0]          body_left;
  logic [12:0]          args_left;
  logic [12:0]          payload_left;
  logic [ARG_IDX_W-1:0] arg_num;

  lprd_result_t expected_tags[$];
  int unsigned  mismatches = 0;
  int unsigned  items_sent = 0;

  // Collects a little-endian header word; 1 when its fourth byte arrives.
  function automatic bit collect_hdr(input logic [7:0] b, output logic [31:0] w);
    hdr_word = hdr_word | (32'(b) << (8 * hdr_cnt));
    hdr_cnt  = hdr_cnt + 2'd1;
    w        = hdr_word;
    if (hdr_cnt != 2'd0) return 1'b0;
    hdr_word = '0;
    return 1'b1;
  endfunction

  // An argument just completed: decide next phase, frame end or error.
  function automatic logic [2:0] close_arg(output logic fl);
    fl      = 1'b0;
    arg_num = arg_num + 1'b1;
    if (args_left != 0) args_left = args_left - 1'b1;
    if (args_left == 0) begin
      if (body_left != 0) return ERR_TRAILING;
      fl       = 1'b1;
      parse_ph = PH_LEN;
      return ERR_NONE;
    end
    if (body_left < HDR_BYTES) return ERR_OVERRUN;
    parse_ph = PH_ARGLEN;
    return ERR_NONE;
  endfunction

  function automatic lprd_result_t tag_byte(input logic [7:0] b);
    lprd_result_t r;
    logic [31:0]  w;
    logic         fl;
    r           = '0;
    r.data_byte = b;
    r.byte_role = ROLE_IGNORED;
    fl          = 1'b0;
    case (parse_ph)
      PH_LEN: begin
        r.byte_role = ROLE_LEN;
        if (collect_hdr(b, w)) begin
          if (w > 32'(MAX_MSG)) begin
            r.error_code = ERR_TOO_LONG;
          end else if (w < HDR_BYTES) begin
            r.error_code = ERR_UNDER_HDR;
          end else begin
            body_left = w[12:0];
            arg_num   = '0;
            parse_ph  = PH_COUNT;
          end
        end
      end
      PH_COUNT: begin
        r.byte_role = ROLE_COUNT;
        if (body_left != 0) body_left = body_left - 1'b1;
        if (collect_hdr(b, w)) begin
          if (w > 32'(MAX_MSG)) begin
            r.error_code = ERR_COUNT;
          end else if (w == 0) begin
            // empty argument list ends the frame right here
            if (body_left == 0) begin
              fl       = 1'b1;
              parse_ph = PH_LEN;
            end else begin
              r.error_code = ERR_TRAILING;
            end
          end else begin
            args_left = w[12:0];
            if (body_left < HDR_BYTES) r.error_code = ERR_OVERRUN;
            else parse_ph = PH_ARGLEN;
          end
        end
      end
      PH_ARGLEN: begin
        r.byte_role = ROLE_ARGLEN;
        r.arg_index = arg_num;
        if (body_left != 0) body_left = body_left - 1'b1;
        if (collect_hdr(b, w)) begin
          if (w > 32'(body_left)) begin
            r.error_code = ERR_OVERRUN;
          end else if (w == 0) begin
            r.arg_last   = 1'b1;
            r.error_code = close_arg(fl);
          end else begin
            payload_left = w[12:0];
            parse_ph     = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        r.byte_role = ROLE_PAYLOAD;
        r.arg_index = arg_num;
        if (body_left != 0) body_left = body_left - 1'b1;
        if (payload_left != 0) payload_left = payload_left - 1'b1;
        if (payload_left == 0) begin
          r.arg_last   = 1'b1;
          r.error_code = close_arg(fl);
        end
      end
      default: parse_ph = PH_ERR;
    endcase
    // first error is sticky; its byte never ends a frame
    if (r.error_code != ERR_NONE) begin
      fl       = 1'b0;
      parse_ph = PH_ERR;
    end
    r.frame_last = fl;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Sender: one byte per call, bursts with random gaps in between
  // --------------------------------------------------------------------------
  int unsigned burst_left = 0;
  int unsigned gap_len    = 0;

  task automatic send_byte(input logic [7:0] b);
    in_valid <= 1'b1;
    in_byte  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_tags.insert(expected_tags.size(), tag_byte(b));
    items_sent++;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      // about a quarter of the bursts run straight into the next one
      gap_len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap_len != 0) begin
        in_valid <= 1'b0;
        repeat (gap_len) @(posedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  task automatic stop_sending();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drain();
    while (expected_tags.size() != 0) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Frame building
  // --------------------------------------------------------------------------
  logic [7:0] frame_q[$];

  function automatic void push_word(input logic [31:0] w);
    for (int k = 0; k < HDR_BYTES; k++) frame_q.insert(frame_q.size(), w[8*k +: 8]);
  endfunction

  function automatic void push_payload(input int unsigned n);
    repeat (n) frame_q.insert(frame_q.size(), 8'($urandom));
  endfunction

  // overwrite the body length in front of the frame
  function automatic void set_length(input logic [31:0] len);
    for (int k = 0; k < HDR_BYTES; k++) frame_q[k] = len[8*k +: 8];
  endfunction

  function automatic void fit_length(input int unsigned extra);
    set_length(frame_q.size() - HDR_BYTES + extra);
  endfunction

  // mostly short arguments, now and then a long one
  function automatic int unsigned pick_arg_len();
    int unsigned sel;
    sel = $urandom_range(0, 19);
    if (sel < 16) return $urandom_range(0, 8);
    if (sel < 19) return $urandom_range(9, 40);
    return $urandom_range(41, 200);
  endfunction

  function automatic void build_random_frame();
    int unsigned nargs;
    int unsigned len;
    int unsigned room;
    frame_q.delete();
    push_word('0);
    nargs = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 20) : $urandom_range(0, 4);
    push_word(nargs);
    // payload bytes that still fit under MAX_MSG
    room = MAX_MSG - HDR_BYTES - HDR_BYTES * nargs;
    repeat (nargs) begin
      len = pick_arg_len();
      if (len > room) len = room;
      room = room - len;
      push_word(len);
      push_payload(len);
    end
    fit_length(0);
  endfunction

  task automatic send_frame();
    foreach (frame_q[k]) send_byte(frame_q[k]);
  endtask

  // --------------------------------------------------------------------------
  // Receiver: stall pattern changes at random intervals; a requested
  // hold-off overrides it for a counted stretch
  // --------------------------------------------------------------------------
  int unsigned hold_req   = 0;
  int unsigned hold_left  = 0;
  int unsigned mode_left  = 0;
  stall_mode_t stall_mode = STALL_NONE;

  always @(posedge clk) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode = stall_mode_t'($urandom_range(0, 3));
        mode_left  = $urandom_range(16, 96);
      end else begin
        mode_left--;
      end
      case (stall_mode)
        STALL_NONE:  out_stall <= 1'b0;
        STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
        default:     out_stall <= ~out_stall;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Result checker: every accepted output item against the oldest expectation
  // --------------------------------------------------------------------------
  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : check_out
    lprd_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_tags.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, actual byte %h role %0d",
                 $time, data_byte, byte_role);
      end else begin
        want = expected_tags.pop_front();
        check_field("data_byte", want.data_byte, data_byte);
        check_field("byte_role", want.byte_role, byte_role);
        check_field("arg_index", want.arg_index, arg_index);
        check_field("arg_last", want.arg_last, arg_last);
        check_field("frame_last", want.frame_last, frame_last);
        check_field("error_code", want.error_code, error_code);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Empty frame, then a frame with a two-byte argument (0x00, 0xFF) followed
  // by a zero-length argument that completes the frame on its length byte.
  task automatic test_directed_frames();
    frame_q.delete();
    push_word(HDR_BYTES);
    push_word('0);
    send_frame();
    frame_q.delete();
    push_word('0);
    push_word(2);
    push_word(2);
    frame_q.insert(frame_q.size(), 8'h00);
    frame_q.insert(frame_q.size(), 8'hFF);
    push_word('0);
    fit_length(0);
    send_frame();
  endtask

  task automatic test_random_frames(input int unsigned n);
    int unsigned start;
    start = items_sent;
    while (items_sent - start < n) begin
      build_random_frame();
      send_frame();
    end
  endtask

  // Output held off for a long stretch while input keeps coming.
  task automatic test_receiver_hold();
    hold_req = HOLD_CYCLES;
    test_random_frames(100);
  endtask

  // Sender goes quiet until every tag is out, then resumes.
  task automatic test_pause_for_drain();
    stop_sending();
    wait_drain();
    test_random_frames(120);
  endtask

  // Largest body: MAX_MSG bytes of zero-length arguments, highest index.
  task automatic test_max_frame();
    int unsigned nargs;
    nargs = (MAX_MSG - HDR_BYTES) / HDR_BYTES;
    frame_q.delete();
    push_word(MAX_MSG);
    push_word(nargs);
    repeat (nargs) push_word('0);
    send_frame();
  endtask

  // One malformed frame of a random kind ends parsing; the noise after it
  // must come back tagged as ignored.
  task automatic test_framing_error();
    logic [2:0]  kind;
    int unsigned k;
    kind = 3'($urandom_range(ERR_TRAILING, ERR_TOO_LONG));
    frame_q.delete();
    case (kind)
      ERR_TOO_LONG:  push_word($urandom_range(32'hFFFF_FFFF, MAX_MSG + 1));
      ERR_UNDER_HDR: push_word($urandom_range(HDR_BYTES - 1, 0));
      ERR_COUNT: begin
        push_word($urandom_range(64, HDR_BYTES));
        push_word($urandom_range(32'hFFFF_FFFF, MAX_MSG + 1));
      end
      ERR_OVERRUN: begin
        case ($urandom_range(0, 2))
          0: begin
            // count leaves under one header of body for its arguments
            push_word($urandom_range(2 * HDR_BYTES - 1, HDR_BYTES));
            push_word($urandom_range(5, 1));
          end
          1: begin
            // argument length exceeds what is left of the body
            k = $urandom_range(0, 20);
            push_word(2 * HDR_BYTES + k);
            push_word(1);
            push_word(k + $urandom_range(1, 50));
          end
          default: begin
            // first argument leaves too little for the second one
            push_word('0);
            push_word(2);
            k = $urandom_range(0, 10);
            push_word(k);
            push_payload(k);
            fit_length($urandom_range(0, HDR_BYTES - 1));
          end
        endcase
      end
      default: begin
        // body declared longer than its arguments
        push_word('0);
        k = $urandom_range(0, 2);
        push_word(k);
        repeat (k) begin
          push_word(3);
          push_payload(3);
        end
        fit_length($urandom_range(1, 10));
      end
    endcase
    send_frame();
    frame_q.delete();
    push_payload($urandom_range(16, 48));
    send_frame();
    stop_sending();
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    parse_ph     = PH_LEN;
    hdr_cnt      = '0;
    hdr_word     = '0;
    body_left    = '0;
    args_left    = '0;
    payload_left = '0;
    arg_num      = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    test_directed_frames();
    test_random_frames(180);
    test_receiver_hold();
    test_pause_for_drain();
    test_max_frame();
    test_random_frames(80);
    test_framing_error();

    wait_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("FAILED: results differ");
    $finish;
  end

endmodule

@@ length_prefixed_request_deframer.f @@
hdl/lprd_pkg.sv
hdl/lprd_parser.sv
hdl/length_prefixed_request_deframer.sv
tb/sv/tb.sv
